### hdl/ssbb_pkg.sv
// Shared types and constants for the sorted sequence block buffer.
`default_nettype none
package ssbb_pkg;

  localparam int DEPTH    = 64;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = IDX_W + 1;
  localparam int SEQ_W    = 32;
  localparam int TAG_BITS = 16;
  localparam int ENTRY_W  = SEQ_W + TAG_BITS;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_PRUNED    = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_PRUNE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_SHIFT,
    S_PLACE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic search_rd;
    logic search_upd;
    logic decide;
    logic shift_step;
    logic place;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_prune;
    logic search_done;
    logic dup;
    logic full;
    logic shift_done;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

### hdl/ssbb_datapath.sv
// Entry store, binary search, shift engine and result register.
`default_nettype none
module ssbb_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ssbb_pkg::cmd_t                    cmd,
  output ssbb_pkg::stat_t                   stat,
  input  logic                              opcode,
  input  logic signed [ssbb_pkg::SEQ_W-1:0] seq_number,
  input  logic [ssbb_pkg::TAG_BITS-1:0]     block_tag,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [1:0]                        status,
  output logic [ssbb_pkg::CNT_W-1:0]        entry_count,
  output logic [ssbb_pkg::CNT_W-1:0]        removed_count
);
  import ssbb_pkg::*;

  logic [ENTRY_W-1:0]      mem [DEPTH];
  logic [ENTRY_W-1:0]      rd_data;
  op_t                     q_op;
  logic signed [SEQ_W-1:0] q_seq;
  logic [TAG_BITS-1:0]     q_tag;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic                    dup_flag;
  logic [CNT_W-1:0]        ptr;
  logic [IDX_W-1:0]        last_rd;
  logic                    sh_vld;
  status_t                 res_status;
  logic [CNT_W-1:0]        res_removed;

  logic [CNT_W:0]          mid_sum;
  logic [IDX_W-1:0]        mid;
  logic [CNT_W-1:0]        ptr_dec;
  logic signed [SEQ_W-1:0] mem_seq;
  logic                    pred;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [ENTRY_W-1:0]      wr_data;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];
  assign ptr_dec = ptr - 1'b1;
  assign mem_seq = signed'(rd_data[ENTRY_W-1:TAG_BITS]);
  assign pred    = (q_op == OP_PRUNE) ? (mem_seq < q_seq) : (mem_seq <= q_seq);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_dec[IDX_W-1:0];
    if (cmd.search_rd) begin
      rd_en   = 1'b1;
      rd_addr = mid;
    end else if (cmd.shift_step && (ptr != lo)) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = last_rd + 1'b1;
    wr_data = rd_data;
    if (cmd.place) begin
      wr_en   = 1'b1;
      wr_addr = lo[IDX_W-1:0];
      wr_data = {q_seq, q_tag};
    end else if (cmd.shift_step && sh_vld) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_op     <= op_t'(opcode);
      q_seq    <= seq_number;
      q_tag    <= block_tag;
      lo       <= '0;
      hi       <= count;
      ptr      <= count;
      dup_flag <= 1'b0;
    end
    if (cmd.search_upd) begin
      if (pred) begin
        hi       <= {1'b0, mid};
        dup_flag <= (mem_seq == q_seq);
      end else begin
        lo <= {1'b0, mid} + 1'b1;
      end
    end
    if (cmd.shift_step && (ptr != lo)) begin
      ptr     <= ptr_dec;
      last_rd <= ptr_dec[IDX_W-1:0];
    end
    if (cmd.decide) begin
      if (q_op == OP_PRUNE) begin
        res_status  <= ST_PRUNED;
        res_removed <= count - lo;
      end else begin
        res_removed <= '0;
        if (dup_flag) begin
          res_status <= ST_DUPLICATE;
        end else if (count == CNT_W'(DEPTH)) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_INSERTED;
        end
      end
    end
    if (cmd.emit) begin
      status        <= res_status;
      entry_count   <= count;
      removed_count <= res_removed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sh_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        sh_vld <= 1'b0;
      end else if (cmd.shift_step) begin
        sh_vld <= (ptr != lo);
      end
      if (cmd.decide && (q_op == OP_PRUNE)) begin
        count <= lo;
      end else if (cmd.place) begin
        count <= count + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.is_prune    = (q_op == OP_PRUNE);
  assign stat.search_done = (lo == hi);
  assign stat.dup         = dup_flag;
  assign stat.full        = (count == CNT_W'(DEPTH));
  assign stat.shift_done  = (ptr == lo);
  assign stat.out_busy    = out_valid && out_stall;

endmodule
`default_nettype wire

### hdl/ssbb_ctrl.sv
// Sequencing state machine for search, shift, place and result hand-off.
`default_nettype none
module ssbb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ssbb_pkg::stat_t stat,
  output ssbb_pkg::cmd_t  cmd
);
  import ssbb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          cmd.decide = 1'b1;
          if (stat.is_prune || stat.dup || stat.full) begin
            state_next = S_RESULT;
          end else begin
            state_next = S_SHIFT;
          end
        end else begin
          cmd.search_rd = 1'b1;
          state_next    = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.search_upd = 1'b1;
        state_next     = S_SEARCH;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/sorted_sequence_block_buffer.sv
// Top level of the sorted sequence block buffer.
//
// Holds up to 64 entries (sequence, tag) ordered highest sequence first. The input
// channel (in_valid, in_stall, opcode, seq_number, block_tag) takes an insert
// or a prune word; the output channel (out_valid, out_stall, status,
// entry_count, removed_count) returns one result word per input word.
// One word is processed at a time: in_stall is high from acceptance until
// the result is loaded into the output register.
// A binary search over the n held entries takes at most ceil(log2(n+1))
// probes, at most 7; each probe is a read (S_SEARCH) then a compare (S_COMPARE).
// Prune, duplicate and full then go to the result; an insert moves each entry
// after its place one slot toward the oldest end and then places the new entry,
// in the worst case with 6 probes and 63 entries moved.
// The next word can be accepted in the cycle after the result is loaded.
// The entry store has one write and one registered read port, which sets
// the shift rate of one entry per cycle.
// The result register lets the next word be accepted while a result waits;
// a stalled result holds until taken, and the following result waits for it.
// Reset empties the buffer at once; the stores need no clearing pass.
`default_nettype none
module sorted_sequence_block_buffer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic signed [ssbb_pkg::SEQ_W-1:0] seq_number,
  input  logic [ssbb_pkg::TAG_BITS-1:0]     block_tag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [ssbb_pkg::CNT_W-1:0]        entry_count,
  output logic [ssbb_pkg::CNT_W-1:0]        removed_count
);
  import ssbb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ssbb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssbb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .opcode        (opcode),
    .seq_number    (seq_number),
    .block_tag     (block_tag),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .entry_count   (entry_count),
    .removed_count (removed_count)
  );

endmodule
`default_nettype wire
